// ----- hw/rtl/blmh_pkg.sv -----
// Shared types and constants for the boot link master handshake sequencer.
`default_nettype none

package blmh_pkg;

  localparam int unsigned CntW = 7;
  localparam logic [CntW-1:0] HeaderHalfwords = 7'd96;

  localparam logic [7:0]  PaletteReset  = 8'h93;
  localparam logic [15:0] WordPoll      = 16'h6200;
  localparam logic [15:0] WordDetect    = 16'h7200;
  localparam logic [15:0] DetectMask    = 16'hfff0;
  localparam logic [15:0] WordConfirm   = 16'h6102;
  localparam logic [15:0] WordAck7202   = 16'h7202;
  localparam logic [15:0] WordAck0002   = 16'h0002;
  localparam logic [15:0] WordStart     = 16'h6202;
  localparam logic [7:0]  PalettePrefix = 8'h63;
  localparam logic [7:0]  ClientPrefix  = 8'h73;
  localparam logic [7:0]  HsPrefix      = 8'h64;
  localparam logic [7:0]  HsSeed        = 8'h11;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_REPLY = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_BUSY = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_e;

  typedef enum logic [8:0] {
    PH_IDLE     = 9'b000000001,
    PH_POLL     = 9'b000000010,
    PH_DETECT   = 9'b000000100,
    PH_CONFIRM  = 9'b000001000,
    PH_HEADER   = 9'b000010000,
    PH_EXPECT2  = 9'b000100000,
    PH_EXPECT72 = 9'b001000000,
    PH_PALETTE  = 9'b010000000,
    PH_FINAL    = 9'b100000000
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [CntW-1:0] count;
    logic [2:0]      mask;
    logic [7:0]      client;
    logic [7:0]      hs;
  } seq_state_t;

  typedef struct packed {
    logic    tx_valid;
    logic [15:0] tx_word;
    status_e status;
  } seq_result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/blmh_step.sv -----
// Next-state and transmit-word logic for one handshake transaction.
`default_nettype none

module blmh_step (
  input  blmh_pkg::seq_state_t  state_i,
  input  logic [7:0]            palette_i,
  input  blmh_pkg::req_e        req_i,
  input  logic [15:0]           rx_word_i,
  input  logic [15:0]           header_word_i,
  output blmh_pkg::seq_state_t  state_o,
  output blmh_pkg::seq_result_t result_o
);
  import blmh_pkg::*;

  logic [3:0]  nib;
  logic [7:0]  hs_new;
  logic [15:0] pal_word;

  assign nib      = rx_word_i[3:0];
  assign hs_new   = 8'(HsSeed + rx_word_i[7:0] + 8'hff + 8'hff);
  assign pal_word = {PalettePrefix, palette_i};

  always_comb begin
    state_o  = state_i;
    result_o = '{tx_valid: 1'b0, tx_word: 16'h0000, status: ST_BUSY};
    if (req_i == REQ_START) begin
      state_o = '{phase: PH_POLL, count: '0, mask: 3'd0, client: 8'd0, hs: 8'd0};
      result_o.tx_valid = 1'b1;
      result_o.tx_word  = WordPoll;
    end else begin
      unique case (state_i.phase)
        PH_POLL: begin
          if (rx_word_i == 16'h0000) state_o.phase = PH_DETECT;
          result_o.tx_valid = 1'b1;
          result_o.tx_word  = WordPoll;
        end
        PH_DETECT: begin
          result_o.tx_valid = 1'b1;
          if ((rx_word_i & DetectMask) == WordDetect) begin
            // only single-client nibbles are recorded
            state_o.mask  = (nib == 4'd1 || nib == 4'd2 || nib == 4'd4) ? nib[2:0] : 3'd0;
            state_o.phase = PH_CONFIRM;
            result_o.tx_word = WordConfirm;
          end else begin
            state_o.phase = PH_POLL;
            result_o.tx_word = WordPoll;
          end
        end
        PH_CONFIRM: begin
          if (rx_word_i == WordAck7202) begin
            state_o.count = CntW'(1);
            state_o.phase = PH_HEADER;
            result_o.tx_valid = 1'b1;
            result_o.tx_word  = header_word_i;
          end else begin
            state_o.phase = PH_IDLE;
            result_o.status = ST_FAIL;
          end
        end
        PH_HEADER: begin
          result_o.tx_valid = 1'b1;
          if (state_i.count < HeaderHalfwords) begin
            state_o.count = state_i.count + CntW'(1);
            result_o.tx_word = header_word_i;
          end else begin
            state_o.phase = PH_EXPECT2;
            result_o.tx_word = WordPoll;
          end
        end
        PH_EXPECT2: begin
          if (rx_word_i == WordAck0002) begin
            state_o.phase = PH_EXPECT72;
            result_o.tx_valid = 1'b1;
            result_o.tx_word  = WordStart;
          end else begin
            state_o.phase = PH_IDLE;
            result_o.status = ST_FAIL;
          end
        end
        PH_EXPECT72: begin
          if (rx_word_i == WordAck7202) begin
            state_o.phase = PH_PALETTE;
            result_o.tx_valid = 1'b1;
            result_o.tx_word  = pal_word;
          end else begin
            state_o.phase = PH_IDLE;
            result_o.status = ST_FAIL;
          end
        end
        PH_PALETTE: begin
          result_o.tx_valid = 1'b1;
          if (rx_word_i[15:8] == ClientPrefix) begin
            state_o.client = rx_word_i[7:0];
            state_o.hs     = hs_new;
            state_o.phase  = PH_FINAL;
            result_o.tx_word = {HsPrefix, hs_new};
          end else begin
            result_o.tx_word = pal_word;
          end
        end
        PH_FINAL: begin
          state_o.phase   = PH_IDLE;
          result_o.status = (rx_word_i[15:8] == ClientPrefix) ? ST_OK : ST_FAIL;
        end
        default: begin
          // idle: replies are dropped
          state_o.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/boot_link_master_handshake_top.sv -----
// Top level of the boot link master handshake sequencer.
//
//  channel | signals                                     | dir | handshake
//  --------+---------------------------------------------+-----+-------------------
//  in      | req_type, rx_word, header_word              | in  | in_valid/in_stall
//  out     | tx_valid, tx_word, status, client_mask,     | out | out_valid/out_stall
//          | client_byte, handshake_byte                 |     |
//  cfg     | cfg_wdata (palette byte)                    | in  | cfg_we
//
// One transaction per cycle unless the output stalls: the phase logic sits
// between input ports and result register, so a result shows up the next cycle.
// A stalled result holds the input off only while it is still waiting.
// Reset puts the sequencer in idle with all captured bytes cleared and the
// palette byte at 0x93.
`default_nettype none

module boot_link_master_handshake_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [15:0] rx_word_i,
  input  logic [15:0] header_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [15:0] tx_word_o,
  output logic [1:0]  status_o,
  output logic [2:0]  client_mask_o,
  output logic [7:0]  client_byte_o,
  output logic [7:0]  handshake_byte_o
);
  import blmh_pkg::*;

  logic [7:0]  pal_q;
  seq_state_t  state_q, state_d;
  seq_result_t res_q, res_d;
  logic        out_valid_q;
  logic        accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  blmh_step u_step (
    .state_i       (state_q),
    .palette_i     (pal_q),
    .req_i         (req_e'(req_type_i)),
    .rx_word_i     (rx_word_i),
    .header_word_i (header_word_i),
    .state_o       (state_d),
    .result_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pal_q <= PaletteReset;
    end else if (cfg_we_i) begin
      pal_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '{phase: PH_IDLE, count: '0, mask: 3'd0, client: 8'd0, hs: 8'd0};
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tx_valid_o       = res_q.tx_valid;
  assign tx_word_o        = res_q.tx_word;
  assign status_o         = res_q.status;
  // state registers only move when a new result is loaded
  assign client_mask_o    = state_q.mask;
  assign client_byte_o    = state_q.client;
  assign handshake_byte_o = state_q.hs;

  a_stall_needs_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_fail_no_tx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FAIL) |-> (!tx_valid_o && state_q.phase == PH_IDLE))
    else $error("failure result with a word to send or not idle");

  a_ok_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_OK) |-> state_q.phase == PH_IDLE)
    else $error("success result while sequencer not idle");

  a_start_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_type_i == REQ_START) |=>
      (client_mask_o == 3'd0 && client_byte_o == 8'd0 && handshake_byte_o == 8'd0
       && state_q.phase == PH_POLL && tx_word_o == WordPoll))
    else $error("start did not clear session state");

  a_no_tx_zero_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !tx_valid_o) |-> tx_word_o == 16'h0000)
    else $error("word present without tx_valid");

endmodule

`default_nettype wire
